[src/msmp_pkg.sv]
// Shared types and constants for the two-state Markov chain sampler.
package msmp_pkg;

  localparam int PROB_BITS = 16;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SQUARINGS = 10;
  localparam int SQ_CNT_W  = $clog2(SQUARINGS);

  localparam logic [PROB_BITS:0] PROB_ONE = (PROB_BITS + 1)'(1) << PROB_BITS;
  localparam logic [32:0]        Q32_ONE  = 33'h1_0000_0000;
  // floor(n/3) == (n * RECIP3) >> 33 for any 32-bit n
  localparam logic [MUL_W-1:0]   RECIP3   = 33'h0_AAAA_AAAB;

  localparam logic [0:0] REG_DECAY_RATE      = 1'b0;
  localparam logic [0:0] REG_INBRED_FRACTION = 1'b1;

  typedef struct packed {
    logic                 start_chain;
    logic signed [31:0]   distance;
    logic [PROB_BITS-1:0] uniform_draw;
  } sample_req_t;

  typedef struct packed {
    logic                 new_state;
    logic [PROB_BITS:0]   stay_zero_probability;
  } result_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_X, ST_T2, ST_T3, ST_T4, ST_D6, ST_D24, ST_SQ, ST_FIN, ST_MP
  } seq_state_t;

endpackage

[src/msmp_mul.sv]
// Shared multiplier with registered product.
module msmp_mul (
  input  logic                      clk,
  input  logic                      en,
  input  logic [msmp_pkg::MUL_W-1:0]  a,
  input  logic [msmp_pkg::MUL_W-1:0]  b,
  output logic [msmp_pkg::PROD_W-1:0] prod
);
  import msmp_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end
endmodule

[src/two_state_markov_chain_sampler_unit.sv]
// Top level: two-state Markov chain sampler with sequencer and shared multiplier.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is the
//    decay rate (Q0.32), index 1 the inbred fraction f (Q0.16). Other indexes
//    are dropped. cfg_ready is always high; write only while idle.
//  - Sample channel (sample_valid/sample_stall, sample): one request per marker.
//  - Result channel (result_valid/result_stall, result): one result per request.
// Sequencing:
//  - Start requests and negative (unlinked) distances: the result register
//    loads on acceptance, and the next request may follow at once.
//  - Linked steps: states X, T2, T3, T4, D6, D24, SQ, FIN, MP; the result
//    register loads in MP and the next request is taken once back in idle.
//    If a*d >= 24, X goes straight to FIN, skipping the series and squarings.
//    One shared 33x33 multiplier does a*d, three powers, two divide-by-constant
//    steps, ten squarings and the final probability product, one per cycle.
// Reset (rst, sync, active high): state 0, rate 2^-16, f 0, no result pending.
// A stalled result holds; a new request is taken only once the result
//  register is free or being drained.
module two_state_markov_chain_sampler_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  msmp_pkg::sample_req_t sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output msmp_pkg::result_req_t result
);
  import msmp_pkg::*;

  localparam int SHIFT = 32 - PROB_BITS;
  localparam logic [33:0] HALF_Q = (34'd1 << SHIFT) >> 1;
  localparam logic [PROD_W-1:0] HALF_P = PROD_W'(PROB_ONE >> 1);

  seq_state_t state, state_next;

  logic [31:0]          decay_rate;
  logic [PROB_BITS-1:0] inbred_fraction;
  logic                 current_state;
  logic [PROB_BITS-1:0] draw;
  logic [31:0]          t, t2, t3, t4, d6;
  logic [32:0]          q;
  logic [SQ_CNT_W-1:0]  cnt;

  logic                 mul_en;
  logic [MUL_W-1:0]     op_a, op_b;
  logic [PROD_W-1:0]    prod;

  logic                 accept;
  logic                 slot_free;
  logic                 direct;
  logic                 result_load;
  logic [PROB_BITS:0]   one_minus_f;
  logic [32:0]          sq;
  logic [34:0]          q_sum;
  logic [33:0]          q_rnd;
  logic [PROB_BITS:0]   e, om, p_sel, r, p0_mp;
  logic                 overflow;

  assign cfg_ready    = 1'b1;
  assign slot_free    = !result_valid || !result_stall;
  assign sample_stall = !((state == ST_IDLE) && slot_free);
  assign accept       = sample_valid && !sample_stall;
  assign direct       = sample.start_chain || sample.distance[31];
  assign one_minus_f  = PROB_ONE - {1'b0, inbred_fraction};
  // result register loads on a direct request or at the end of a linked step
  assign result_load  = (accept && direct) || (state == ST_MP);

  // datapath helpers
  assign overflow = prod[PROD_W-1:32] >= (PROD_W - 32)'(24);
  assign sq = q[32] ? Q32_ONE : 33'((prod[63:0] + 64'h8000_0000) >> 32);
  assign q_sum = 35'(Q32_ONE) - 35'(t) + 35'(t2 >> 1) - 35'(d6)
               + 35'(prod[PROD_W-1:33]);
  assign q_rnd = ({1'b0, q} + HALF_Q) >> SHIFT;
  assign e     = (q_rnd > 34'(PROB_ONE)) ? PROB_ONE : q_rnd[PROB_BITS:0];
  assign om    = PROB_ONE - e;
  assign p_sel = current_state ? one_minus_f : {1'b0, inbred_fraction};
  assign r     = (PROB_BITS + 1)'((prod + HALF_P) >> PROB_BITS);
  assign p0_mp = current_state ? r : PROB_ONE - r;

  msmp_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (op_a),
    .b    (op_b),
    .prod (prod)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && !direct) state_next = ST_X;
      ST_X:    state_next = overflow ? ST_FIN : ST_T2;
      ST_T2:   state_next = ST_T3;
      ST_T3:   state_next = ST_T4;
      ST_T4:   state_next = ST_D6;
      ST_D6:   state_next = ST_D24;
      ST_D24:  state_next = ST_SQ;
      ST_SQ:   if (cnt == SQ_CNT_W'(SQUARINGS - 1)) state_next = ST_FIN;
      ST_FIN:  state_next = ST_MP;
      ST_MP:   state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    op_a   = '0;
    op_b   = '0;
    unique case (state)
      ST_IDLE: begin
        mul_en = accept && !direct;
        op_a   = MUL_W'(decay_rate);
        op_b   = MUL_W'(sample.distance[30:0]);
      end
      ST_X: begin
        mul_en = 1'b1;
        op_a   = MUL_W'(prod[41:10]);
        op_b   = MUL_W'(prod[41:10]);
      end
      ST_T2: begin
        mul_en = 1'b1;
        op_a   = MUL_W'(prod[63:32]);
        op_b   = MUL_W'(t);
      end
      ST_T3: begin
        mul_en = 1'b1;
        op_a   = MUL_W'(prod[63:32]);
        op_b   = MUL_W'(t);
      end
      ST_T4: begin
        mul_en = 1'b1;
        op_a   = MUL_W'(t3 >> 1);
        op_b   = RECIP3;
      end
      ST_D6: begin
        mul_en = 1'b1;
        op_a   = MUL_W'(t4 >> 3);
        op_b   = RECIP3;
      end
      ST_D24: begin
        mul_en = 1'b1;
        op_a   = q_sum[32:0];
        op_b   = q_sum[32:0];
      end
      ST_SQ: begin
        mul_en = 1'b1;
        op_a   = sq;
        op_b   = sq;
      end
      ST_FIN: begin
        mul_en = 1'b1;
        op_a   = MUL_W'(p_sel);
        op_b   = MUL_W'(om);
      end
      ST_MP:   mul_en = 1'b0;
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      decay_rate      <= 32'h0001_0000;
      inbred_fraction <= '0;
      current_state   <= 1'b0;
      result_valid    <= 1'b0;
      cnt             <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == {1'b0, REG_DECAY_RATE}) begin
          decay_rate <= cfg_data;
        end else if (cfg_index == {1'b0, REG_INBRED_FRACTION}) begin
          inbred_fraction <= cfg_data[PROB_BITS-1:0];
        end
      end
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        draw <= sample.uniform_draw;
        if (sample.start_chain) begin
          current_state                <= sample.uniform_draw < inbred_fraction;
          result.new_state             <= sample.uniform_draw < inbred_fraction;
          result.stay_zero_probability <= one_minus_f;
        end else if (sample.distance[31]) begin
          // unlinked marker
          current_state                <= !({1'b0, sample.uniform_draw} < one_minus_f);
          result.new_state             <= !({1'b0, sample.uniform_draw} < one_minus_f);
          result.stay_zero_probability <= one_minus_f;
        end
      end
      case (state)
        ST_X: begin
          t <= prod[41:10];
          if (overflow) q <= '0;
        end
        ST_T2:  t2 <= prod[63:32];
        ST_T3:  t3 <= prod[63:32];
        ST_T4:  t4 <= prod[63:32];
        ST_D6:  d6 <= prod[64:33];
        ST_D24: begin
          q   <= q_sum[32:0];
          cnt <= '0;
        end
        ST_SQ: begin
          q   <= sq;
          cnt <= cnt + 1'b1;
        end
        ST_MP: begin
          current_state                <= !({1'b0, draw} < p0_mp);
          result.new_state             <= !({1'b0, draw} < p0_mp);
          result.stay_zero_probability <= p0_mp;
        end
        default: ;
      endcase
    end
  end
endmodule

[src/msmp_checker.sv]
// Port-level checker for the sampler, bound to the top level.
module msmp_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  sample_valid,
  input logic                  sample_stall,
  input msmp_pkg::sample_req_t sample,
  input logic                  result_valid,
  input logic                  result_stall,
  input msmp_pkg::result_req_t result
);
  import msmp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall && !sample.start_chain && !sample.distance[31]
    |=> sample_stall)
    else $error("linked step did not hold off next request");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.stay_zero_probability <= PROB_ONE)
    else $error("probability above one");

  a_sure: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.stay_zero_probability == PROB_ONE |-> !result.new_state)
    else $error("certain stay-zero gave state one");
endmodule

bind two_state_markov_chain_sampler_unit msmp_checker u_msmp_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .sample       (sample),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

[dv/testbench.sv]
// Testbench for the two-state Markov chain sampler: directed and random requests
`timescale 1ns / 1ps

module testbench;
  import msmp_pkg::*;

  // Register indexes as driven on the 2-bit config bus; index 2 is unmapped.
  localparam logic [1:0] IDX_RATE     = 2'(REG_DECAY_RATE);
  localparam logic [1:0] IDX_FRACTION = 2'(REG_INBRED_FRACTION);
  localparam logic [1:0] IDX_UNMAPPED = 2'd2;
  localparam logic [1:0] IDX_LAST     = 2'd3;

  localparam longint ONE_P     = 64'd1 << PROB_BITS;
  localparam longint Q32       = 64'd1 << 32;
  localparam int     CYCLE_CAP = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  sample_req_t sample = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_req_t result;

  two_state_markov_chain_sampler_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: shadow registers and chain state.
  longint      rate_q16 = 65536;
  longint      frac_f = 0;
  bit          chain_state = 1'b0;
  result_req_t expected_results[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic longint square_q32(input longint q);
    if (q >= Q32) return Q32;
    return longint'((64'(q) * 64'(q) + (64'd1 << 31)) >> 32);
  endfunction

  // exp(-a*d) in Q0.16 via truncated 5-term series and ten squarings.
  function automatic longint decay_factor(input longint a, input longint d);
    logic [63:0] x, t, t2, t3, t4, q;
    x = 64'(a) * 64'(d);
    if (x >= (64'd24 << 32)) return 0;
    t  = x >> SQUARINGS;
    t2 = (t * t) >> 32;
    t3 = (t2 * t) >> 32;
    t4 = (t3 * t) >> 32;
    q = Q32 - t + (t2 >> 1) - t3 / 6 + t4 / 24;
    for (int k = 0; k < SQUARINGS; k++) q = square_q32(q);
    q = (q + (64'd1 << (31 - PROB_BITS))) >> (32 - PROB_BITS);
    if (q > ONE_P) q = ONE_P;
    return q;
  endfunction

  function automatic longint mul_prob(input longint p, input longint q);
    return (p * q + (ONE_P >> 1)) >> PROB_BITS;
  endfunction

  function automatic result_req_t predict_transition(input sample_req_t s);
    result_req_t r;
    longint p0, om;
    if (s.start_chain) begin
      chain_state = (s.uniform_draw < frac_f);
      p0 = ONE_P - frac_f;
    end else begin
      if (s.distance[31]) begin
        p0 = ONE_P - frac_f;  // unlinked marker
      end else begin
        om = ONE_P - decay_factor(rate_q16, longint'(unsigned'(s.distance)));
        if (chain_state) p0 = mul_prob(ONE_P - frac_f, om);
        else p0 = ONE_P - mul_prob(frac_f, om);
      end
      if (p0 > ONE_P) p0 = ONE_P;
      chain_state = !(s.uniform_draw < p0);
    end
    r.new_state = chain_state;
    r.stay_zero_probability = p0[PROB_BITS:0];
    return r;
  endfunction

  // Sends one request: random idle gaps ahead, then hold until accepted.
  // Valid stays high after acceptance so requests can go back to back.
  task automatic send_sample(input bit start, input logic [31:0] span, input logic [15:0] draw);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= '{start_chain: start, distance: span, uniform_draw: draw};
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    expected_results.push_back(predict_transition(sample));
    @(negedge clk);
  endtask

  // Waits for all expected results, plus the latency of a linked step.
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == IDX_RATE) rate_q16 = value;
    else if (idx == IDX_FRACTION) frac_f = value[15:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Checker: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    result_req_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", result, 0);
      end else begin
        want = expected_results.pop_front();
        if (result.new_state !== want.new_state)
          report_mismatch("new_state", result.new_state, want.new_state);
        if (result.stay_zero_probability !== want.stay_zero_probability)
          report_mismatch("stay_zero_probability", result.stay_zero_probability,
                          want.stay_zero_probability);
      end
    end
  end

  // Receiver stall driven at the falling edge.
  always @(negedge clk) result_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("two_state_markov_chain_sampler_unit: mismatch");
      $finish;
    end
  end

  // Directed: field extremes, start, zero/negative distance, zero rate.
  task automatic test_directed();
    send_sample(1'b1, 32'd0, 16'd0);
    send_sample(1'b0, 32'd0, 16'hFFFF);
    send_sample(1'b0, 32'h8000_0000, 16'h0000);
    drain_results();
    write_reg(IDX_FRACTION, 32'hFFFF_8000);  // upper bits ignored
    send_sample(1'b1, 32'h7FFF_FFFF, 16'h7FFF);
    send_sample(1'b0, 32'd0, 16'hFFFF);
    send_sample(1'b0, 32'h0001_0000, 16'h4000);
    send_sample(1'b0, 32'h7FFF_FFFF, 16'hFFFF);
    send_sample(1'b0, 32'hFFFF_FFFF, 16'h0001);
    send_sample(1'b0, 32'd1, 16'h8000);
    drain_results();
    write_reg(IDX_RATE, 32'd0);
    send_sample(1'b0, 32'h0100_0000, 16'hFFFF);
    send_sample(1'b1, 32'd0, 16'h0000);
    send_sample(1'b0, 32'h0100_0000, 16'h0000);
    drain_results();
    write_reg(IDX_UNMAPPED, 32'd5);
    write_reg(IDX_LAST, 32'd7);
    write_reg(IDX_RATE, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'd1, 16'hFFFF);
    send_sample(1'b0, 32'd2, 16'h1234);
    send_sample(1'b0, 32'h0000_0100, 16'h9000);
    drain_results();
  endtask

  // Random: chains of linked steps, some unlinked or huge distances.
  task automatic test_random(input int count);
    logic [31:0] span;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: span = $urandom;
        1: span = 32'h8000_0000 | $urandom;
        2, 3: span = $urandom_range(255);
        default: span = $urandom_range(32'h0004_0000);
      endcase
      send_sample($urandom_range(15) == 0, span, 16'($urandom));
    end
  endtask

  task automatic test_phase(input int idle, input int stall, input logic [31:0] rate,
                            input logic [31:0] frac, input int count);
    drain_results();
    write_reg(IDX_RATE, rate);
    write_reg(IDX_FRACTION, frac);
    send_idle_pct = idle;
    stall_pct = stall;
    test_random(count);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_phase(0, 0, 32'h0001_0000, 32'h0000_4000, 250);
    test_phase(58, 0, 32'h0000_0400, 32'h0000_FFFF, 250);
    test_phase(0, 58, 32'h0010_0000, 32'h0000_0000, 250);
    test_phase(8, 8, $urandom, $urandom, 150);
    test_phase(0, 0, 32'h0000_0001, 32'h0000_8000, 100);
    drain_results();
    if (error_count == 0) begin
      $display("two_state_markov_chain_sampler_unit: match");
    end else begin
      $display("two_state_markov_chain_sampler_unit: mismatch");
    end
    $finish;
  end
endmodule
